// File: sv/hbr_pkg.sv
// Package for the HTTP byte-range parser: status codes, character constants,
// the "bytes=" prefix table and the header summary handed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbr_pkg;

    // Widths fixed by the channel payloads
    localparam int SIZE_BITS = 48;
    localparam int BYTE_BITS = 8;

    // Depth of the summary queue between parser front and verdict back
    localparam int QUEUE_DEPTH = 2;

    // Prefix handling
    localparam logic [2:0] PREFIX_LEN = 3'd6;

    // Dash count saturates here
    localparam logic [1:0] DASH_MAX = 2'd2;

    // Characters of interest
    localparam logic [BYTE_BITS-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_BITS-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_VALID     = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_UNSAT     = 2'd3
    } t_status;

    // Classified header, one per end of header
    typedef struct packed {
        logic any_byte;
        logic hdr_ok;        // full prefix matched and no comma
        logic dash_one;
        logic start_present;
        logic start_bad;
        logic end_present;
        logic end_bad;
    } t_hdr_flags;

    // Expected character of "bytes=" at a given position
    function automatic logic [BYTE_BITS-1:0] prefix_char(input logic [2:0] idx);
        logic [BYTE_BITS-1:0] c;
        case (idx)
            3'd0:    c = 8'h62;  // b
            3'd1:    c = 8'h79;  // y
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h65;  // e
            3'd4:    c = 8'h73;  // s
            3'd5:    c = 8'h3D;  // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/hbr_in_if.sv
// Input channel of the byte-range parser: at most one header character per transaction.
// Depends on hbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hbr_in_if import hbr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [BYTE_BITS-1:0]  header_byte;
    logic                  has_byte;
    logic                  end_of_header;
    logic [SIZE_BITS-1:0]  file_size;

    modport source (output valid, header_byte, has_byte, end_of_header, file_size,
                    input ready);
    modport sink   (input valid, header_byte, has_byte, end_of_header, file_size,
                    output ready);
endinterface

`default_nettype wire

// File: sv/hbr_out_if.sv
// Output channel of the byte-range parser: one verdict per transaction.
// Depends on hbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hbr_out_if import hbr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [SIZE_BITS-1:0]  range_first;
    logic [SIZE_BITS-1:0]  range_last;

    modport source (output valid, status, range_first, range_last, input ready);
    modport sink   (input valid, status, range_first, range_last, output ready);
endinterface

`default_nettype wire

// File: sv/hbr_front.sv
// Parser front: takes header characters, tracks prefix, comma and dash, and
// accumulates the two decimal numbers; pushes a summary at end of header.
// Depends on hbr_pkg and hbr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module hbr_front import hbr_pkg::*; #(
    parameter int POSITION_BITS = 48
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    hbr_in_if.sink                         i_in,
    input  wire logic                      i_q_full,
    output      logic                      o_push,
    output      t_hdr_flags                o_flags,
    output      logic [POSITION_BITS-1:0]  o_start,
    output      logic [POSITION_BITS-1:0]  o_end,
    output      logic [SIZE_BITS-1:0]      o_size,
    output      logic [SIZE_BITS-1:0]      o_size_m1
);

    logic [2:0]               r_pos,           n_pos;
    logic                     r_mismatch,      n_mismatch;
    logic                     r_any,           n_any;
    logic                     r_comma,         n_comma;
    logic [1:0]               r_dash,          n_dash;
    logic [POSITION_BITS-1:0] r_start_val,     n_start_val;
    logic                     r_start_present, n_start_present;
    logic                     r_start_bad,     n_start_bad;
    logic [POSITION_BITS-1:0] r_end_val,       n_end_val;
    logic                     r_end_present,   n_end_present;
    logic                     r_end_bad,       n_end_bad;

    logic                     w_take;
    logic [BYTE_BITS-1:0]     w_c;
    logic                     w_is_digit;
    logic [3:0]               w_digit;
    logic [BYTE_BITS-1:0]     w_digit_full;
    logic [POSITION_BITS-1:0] w_acc;
    logic [POSITION_BITS+3:0] w_acc_ext;
    logic [POSITION_BITS+3:0] w_ten;
    logic                     w_ovf;

    assign i_in.ready = !i_q_full;
    assign w_take     = i_in.valid && i_in.ready && i_in.has_byte;
    assign o_push     = i_in.valid && i_in.ready && i_in.end_of_header;

    // Shared decimal accumulator: acc * 10 + digit, with overflow above the width
    assign w_c          = i_in.header_byte;
    assign w_is_digit   = (w_c >= CHAR_ZERO) && (w_c <= CHAR_NINE);
    assign w_digit_full = w_c - CHAR_ZERO;
    assign w_digit      = w_digit_full[3:0];
    assign w_acc        = (r_dash == 2'd0) ? r_start_val : r_end_val;
    assign w_acc_ext    = {4'b0, w_acc};
    assign w_ten        = (w_acc_ext << 3) + (w_acc_ext << 1)
                        + {{POSITION_BITS{1'b0}}, w_digit};
    assign w_ovf        = |w_ten[POSITION_BITS+3:POSITION_BITS];

    // Character classification and state update
    always_comb begin
        n_pos           = r_pos;
        n_mismatch      = r_mismatch;
        n_any           = r_any;
        n_comma         = r_comma;
        n_dash          = r_dash;
        n_start_val     = r_start_val;
        n_start_present = r_start_present;
        n_start_bad     = r_start_bad;
        n_end_val       = r_end_val;
        n_end_present   = r_end_present;
        n_end_bad       = r_end_bad;
        if (w_take) begin
            n_any = 1'b1;
            if (w_c == CHAR_COMMA) begin
                n_comma = 1'b1;
            end
            if (r_pos < PREFIX_LEN) begin
                if (w_c != prefix_char(r_pos)) begin
                    n_mismatch = 1'b1;
                end
                n_pos = r_pos + 3'd1;
            end else if (w_c == CHAR_DASH) begin
                if (r_dash != DASH_MAX) begin
                    n_dash = r_dash + 2'd1;
                end
            end else if (r_dash == 2'd0) begin
                n_start_present = 1'b1;
                if (!r_start_bad) begin
                    if (!w_is_digit || w_ovf) begin
                        n_start_bad = 1'b1;
                    end else begin
                        n_start_val = w_ten[POSITION_BITS-1:0];
                    end
                end
            end else if (r_dash == 2'd1) begin
                n_end_present = 1'b1;
                if (!r_end_bad) begin
                    if (!w_is_digit || w_ovf) begin
                        n_end_bad = 1'b1;
                    end else begin
                        n_end_val = w_ten[POSITION_BITS-1:0];
                    end
                end
            end
        end
    end

    // Summary of the header including the final character
    always_comb begin
        o_flags.any_byte      = n_any;
        o_flags.hdr_ok        = (n_pos == PREFIX_LEN) && !n_mismatch && !n_comma;
        o_flags.dash_one      = (n_dash == 2'd1);
        o_flags.start_present = n_start_present;
        o_flags.start_bad     = n_start_bad;
        o_flags.end_present   = n_end_present;
        o_flags.end_bad       = n_end_bad;
    end

    assign o_start   = n_start_val;
    assign o_end     = n_end_val;
    assign o_size    = i_in.file_size;
    assign o_size_m1 = i_in.file_size - {{(SIZE_BITS-1){1'b0}}, 1'b1};

    // Parser state, cleared after every header
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos           <= '0;
            r_mismatch      <= 1'b0;
            r_any           <= 1'b0;
            r_comma         <= 1'b0;
            r_dash          <= '0;
            r_start_val     <= '0;
            r_start_present <= 1'b0;
            r_start_bad     <= 1'b0;
            r_end_val       <= '0;
            r_end_present   <= 1'b0;
            r_end_bad       <= 1'b0;
        end else begin
            r_pos           <= n_pos;
            r_mismatch      <= n_mismatch;
            r_any           <= n_any;
            r_comma         <= n_comma;
            r_dash          <= n_dash;
            r_start_val     <= n_start_val;
            r_start_present <= n_start_present;
            r_start_bad     <= n_start_bad;
            r_end_val       <= n_end_val;
            r_end_present   <= n_end_present;
            r_end_bad       <= n_end_bad;
        end
    end

endmodule

`default_nettype wire

// File: sv/hbr_queue.sv
// Small FIFO that holds header summaries between parser front and verdict back.
// Depends on hbr_pkg only through the widths chosen by its parent.
`timescale 1ns / 1ps
`default_nettype none

module hbr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output      logic             o_full,
    input  wire logic             i_pop,
    output      logic [WIDTH-1:0] o_data,
    output      logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/hbr_back.sv
// Verdict back end: compares the parsed numbers with the file size, then
// decides status and range into the output register.
// Depends on hbr_pkg and hbr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module hbr_back import hbr_pkg::*; #(
    parameter int POSITION_BITS = 48
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_empty,
    output      logic                      o_pop,
    input  wire t_hdr_flags                i_flags,
    input  wire logic [POSITION_BITS-1:0]  i_start,
    input  wire logic [POSITION_BITS-1:0]  i_end,
    input  wire logic [SIZE_BITS-1:0]      i_size,
    input  wire logic [SIZE_BITS-1:0]      i_size_m1,
    hbr_out_if.source                      o_out
);

    localparam int CW = (POSITION_BITS > SIZE_BITS) ? POSITION_BITS : SIZE_BITS;

    typedef struct packed {
        logic size_zero;
        logic start_ge_size;
        logic end_lt_start;
        logic end_lt_sm1;
        logic end_lt_size;
        logic end_zero;
    } t_cmp;

    // Stage A: comparisons
    logic                     r_a_valid;
    t_hdr_flags               r_a_flags;
    logic [POSITION_BITS-1:0] r_a_start;
    logic [POSITION_BITS-1:0] r_a_end;
    logic [SIZE_BITS-1:0]     r_a_size;
    logic [SIZE_BITS-1:0]     r_a_size_m1;
    t_cmp                     r_a_cmp;

    // Output register
    logic                     r_o_valid;
    t_status                  r_status,  n_status;
    logic [SIZE_BITS-1:0]     r_first,   n_first;
    logic [SIZE_BITS-1:0]     r_last,    n_last;

    logic                     w_b_load;
    logic                     w_a_adv;
    logic [CW-1:0]            w_s, w_e, w_z, w_zm1;
    t_cmp                     w_cmp;
    logic [CW-1:0]            w_as_ext, w_ae_ext;
    logic [SIZE_BITS-1:0]     w_as48, w_ae48;
    logic [SIZE_BITS-1:0]     w_suffix;
    logic [SIZE_BITS-1:0]     w_suffix_first;

    // Pipeline flow control
    assign w_b_load = !r_o_valid || o_out.ready;
    assign w_a_adv  = !r_a_valid || w_b_load;
    assign o_pop    = !i_q_empty && w_a_adv;

    // Size comparisons on the queue head
    assign w_s   = CW'(i_start);
    assign w_e   = CW'(i_end);
    assign w_z   = CW'(i_size);
    assign w_zm1 = CW'(i_size_m1);

    always_comb begin
        w_cmp.size_zero     = (i_size == '0);
        w_cmp.start_ge_size = (w_s >= w_z);
        w_cmp.end_lt_start  = (w_e < w_s);
        w_cmp.end_lt_sm1    = (w_e < w_zm1);
        w_cmp.end_lt_size   = (w_e < w_z);
        w_cmp.end_zero      = (i_end == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_adv) begin
            r_a_valid <= o_pop;
        end
        if (o_pop) begin
            r_a_flags   <= i_flags;
            r_a_start   <= i_start;
            r_a_end     <= i_end;
            r_a_size    <= i_size;
            r_a_size_m1 <= i_size_m1;
            r_a_cmp     <= w_cmp;
        end
    end

    // Stage B: verdict in the checking order of the header rules
    assign w_as_ext       = CW'(r_a_start);
    assign w_ae_ext       = CW'(r_a_end);
    assign w_as48         = w_as_ext[SIZE_BITS-1:0];
    assign w_ae48         = w_ae_ext[SIZE_BITS-1:0];
    assign w_suffix       = r_a_cmp.end_lt_size ? w_ae48 : r_a_size;
    assign w_suffix_first = r_a_size - w_suffix;

    always_comb begin
        n_status = ST_MALFORMED;
        n_first  = '0;
        n_last   = '0;
        if (!r_a_flags.any_byte) begin
            n_status = ST_NONE;
            n_last   = r_a_cmp.size_zero ? '0 : r_a_size_m1;
        end else if (!r_a_flags.hdr_ok) begin
            n_status = ST_MALFORMED;
        end else if (r_a_cmp.size_zero) begin
            n_status = ST_UNSAT;
        end else if (!r_a_flags.dash_one) begin
            n_status = ST_MALFORMED;
        end else if (!r_a_flags.start_present) begin
            // suffix form: last N bytes
            if (r_a_flags.end_present && !r_a_flags.end_bad && !r_a_cmp.end_zero) begin
                n_status = ST_VALID;
                n_first  = w_suffix_first;
                n_last   = r_a_size_m1;
            end
        end else if (r_a_flags.start_bad) begin
            n_status = ST_MALFORMED;
        end else if (r_a_cmp.start_ge_size) begin
            n_status = ST_UNSAT;
        end else if (!r_a_flags.end_present) begin
            // open end
            n_status = ST_VALID;
            n_first  = w_as48;
            n_last   = r_a_size_m1;
        end else if (r_a_flags.end_bad) begin
            n_status = ST_MALFORMED;
        end else if (r_a_cmp.end_lt_start) begin
            n_status = ST_UNSAT;
        end else begin
            n_status = ST_VALID;
            n_first  = w_as48;
            n_last   = r_a_cmp.end_lt_sm1 ? w_ae48 : r_a_size_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_b_load) begin
            r_o_valid <= r_a_valid;
        end
        if (w_b_load && r_a_valid) begin
            r_status <= n_status;
            r_first  <= n_first;
            r_last   <= n_last;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.status      = r_status;
    assign o_out.range_first = r_first;
    assign o_out.range_last  = r_last;

endmodule

`default_nettype wire

// File: sv/http_byte_range_parser.sv
// HTTP byte-range parser, top level.
//
// Usage: i_in carries the Range header one character per transaction
// (has_byte = 0 carries no character). The transaction with end_of_header = 1
// closes the header; file_size is sampled on it. o_out then gives one verdict:
// status (none, valid, malformed, unsatisfiable) with range_first/range_last.
// Headers without end_of_header give no output.
//
// Throughput: one input transaction per cycle while the summary queue is not
// full, headers back to back. The final transaction's summary passes through
// the summary queue, then the compare stage, then the output register.
// The parser updates its decimal accumulator with one multiply-by-ten add per
// character; the compare stage and the decision stage are each one register.
//
// Stalls: the output register, compare stage and a two-entry summary queue
// hold up to four verdicts; i_in.ready drops only when the queue is full.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears the parser.
// Depends on hbr_pkg, hbr_in_if, hbr_out_if, hbr_front, hbr_queue, hbr_back.
`timescale 1ns / 1ps
`default_nettype none

module http_byte_range_parser import hbr_pkg::*; #(
    parameter int POSITION_BITS = 48
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hbr_in_if.sink     i_in,
    hbr_out_if.source  o_out
);

    localparam int QW = $bits(t_hdr_flags) + 2 * POSITION_BITS + 2 * SIZE_BITS;

    logic                     w_push;
    logic                     w_pop;
    logic                     w_q_full;
    logic                     w_q_empty;
    t_hdr_flags               w_f_flags;
    logic [POSITION_BITS-1:0] w_f_start;
    logic [POSITION_BITS-1:0] w_f_end;
    logic [SIZE_BITS-1:0]     w_f_size;
    logic [SIZE_BITS-1:0]     w_f_size_m1;
    logic [QW-1:0]            w_q_wdata;
    logic [QW-1:0]            w_q_rdata;
    t_hdr_flags               w_q_flags;
    logic [POSITION_BITS-1:0] w_q_start;
    logic [POSITION_BITS-1:0] w_q_end;
    logic [SIZE_BITS-1:0]     w_q_size;
    logic [SIZE_BITS-1:0]     w_q_size_m1;

    // Parser front
    hbr_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_flags   (w_f_flags),
        .o_start   (w_f_start),
        .o_end     (w_f_end),
        .o_size    (w_f_size),
        .o_size_m1 (w_f_size_m1)
    );

    // Summary queue
    assign w_q_wdata = {w_f_flags, w_f_start, w_f_end, w_f_size, w_f_size_m1};

    hbr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    assign {w_q_flags, w_q_start, w_q_end, w_q_size, w_q_size_m1} = w_q_rdata;

    // Verdict back end
    hbr_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .i_flags   (w_q_flags),
        .i_start   (w_q_start),
        .i_end     (w_q_end),
        .i_size    (w_q_size),
        .i_size_m1 (w_q_size_m1),
        .o_out     (o_out)
    );

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("summary queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("summary queue read while empty");

    a_valid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_VALID)) |->
            (o_out.range_first <= o_out.range_last))
        else $error("valid range with first past last");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for http_byte_range_parser: directed and random Range headers with a
// built-in parser model, random idling on both channels and one long output stall.
// Depends on hbr_pkg, hbr_in_if, hbr_out_if and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
    import hbr_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_ITEMS  = 700;
    localparam int          QUIET_TAIL    = 120;
    localparam int          HOLD_AT       = 300;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          DRAIN_CYCLES  = 8;
    localparam logic [63:0] POS_LIMIT     = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct {
        logic [7:0]           ch;
        bit                   has;
        bit                   eoh;
        logic [SIZE_BITS-1:0] size;
    } t_hdr_item;

    typedef struct {
        t_status              status;
        logic [SIZE_BITS-1:0] first;
        logic [SIZE_BITS-1:0] last;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    hbr_in_if  in_if ();
    hbr_out_if out_if ();

    http_byte_range_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    t_hdr_item  pending_items[$];
    t_verdict   verdict_q[$];
    logic [7:0] hdr_buf[$];
    int         cycle_count    = 0;
    int         mismatches     = 0;
    int         accepted_items = 0;
    int         stim_items     = 0;
    bit         in_fired       = 1'b0;
    int         src_gap        = 0;
    int         snk_gap        = 0;
    int         hold_left      = 0;
    bit         hold_done      = 1'b0;

    // Model state of the header parser
    string       prefix_text = "bytes=";
    logic [2:0]  pfx_pos;
    bit          pfx_bad;
    bit          saw_byte;
    bit          saw_comma;
    logic [1:0]  dashes;
    logic [63:0] first_num;
    bit          first_seen;
    bit          first_bad;
    logic [63:0] last_num;
    bit          last_seen;
    bit          last_bad;

    // Queue append helpers
    task automatic append_char(input logic [7:0] c);
        hdr_buf = {hdr_buf, c};
    endtask

    task automatic append_item(input t_hdr_item it);
        pending_items = {pending_items, it};
    endtask

    task automatic append_verdict(input t_verdict v);
        verdict_q = {verdict_q, v};
    endtask

    task automatic clear_parser();
        pfx_pos    = '0;
        pfx_bad    = 1'b0;
        saw_byte   = 1'b0;
        saw_comma  = 1'b0;
        dashes     = '0;
        first_num  = '0;
        first_seen = 1'b0;
        first_bad  = 1'b0;
        last_num   = '0;
        last_seen  = 1'b0;
        last_bad   = 1'b0;
    endtask

    // Decimal accumulate; too wide or non-digit marks the number bad for good
    task automatic accum_digit(input logic [7:0] c, inout logic [63:0] v,
                               inout bit seen, inout bit bad);
        logic [63:0] d;
        seen = 1'b1;
        if (!bad) begin
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
                bad = 1'b1;
            end else begin
                d = 64'(c - CHAR_ZERO);
                if (v > (POS_LIMIT - d) / 10) bad = 1'b1;
                else v = v * 10 + d;
            end
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        saw_byte = 1'b1;
        if (c == CHAR_COMMA) saw_comma = 1'b1;
        if (pfx_pos < PREFIX_LEN) begin
            if (c != 8'(prefix_text[pfx_pos])) pfx_bad = 1'b1;
            pfx_pos = pfx_pos + 3'd1;
        end else if (c == CHAR_DASH) begin
            if (dashes < DASH_MAX) dashes = dashes + 2'd1;
        end else if (dashes == 2'd0) begin
            accum_digit(c, first_num, first_seen, first_bad);
        end else if (dashes == 2'd1) begin
            accum_digit(c, last_num, last_seen, last_bad);
        end
    endtask

    function automatic t_verdict judge_header(input logic [SIZE_BITS-1:0] size);
        t_verdict    r;
        logic [63:0] sz;
        logic [63:0] suffix;
        sz      = 64'(size);
        r.status = ST_MALFORMED;
        r.first  = '0;
        r.last   = '0;
        if (!saw_byte) begin
            r.status = ST_NONE;
            r.last   = (sz == 0) ? '0 : SIZE_BITS'(sz - 1);
        end else if (pfx_pos < PREFIX_LEN || pfx_bad || saw_comma) begin
            r.status = ST_MALFORMED;
        end else if (sz == 0) begin
            r.status = ST_UNSAT;
        end else if (dashes != 2'd1) begin
            r.status = ST_MALFORMED;
        end else if (!first_seen) begin
            // suffix form: last N bytes
            if (last_seen && !last_bad && last_num != 0) begin
                suffix   = (last_num < sz) ? last_num : sz;
                r.status = ST_VALID;
                r.first  = SIZE_BITS'(sz - suffix);
                r.last   = SIZE_BITS'(sz - 1);
            end
        end else if (first_bad) begin
            r.status = ST_MALFORMED;
        end else if (first_num >= sz) begin
            r.status = ST_UNSAT;
        end else if (!last_seen) begin
            r.status = ST_VALID;
            r.first  = SIZE_BITS'(first_num);
            r.last   = SIZE_BITS'(sz - 1);
        end else if (last_bad) begin
            r.status = ST_MALFORMED;
        end else if (last_num < first_num) begin
            r.status = ST_UNSAT;
        end else begin
            r.status = ST_VALID;
            r.first  = SIZE_BITS'(first_num);
            r.last   = SIZE_BITS'((last_num < sz - 1) ? last_num : sz - 1);
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [SIZE_BITS-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[SIZE_BITS-1:0];
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) append_char(8'(s[i]));
    endtask

    // Turn hdr_buf into input transactions, with ignored filler mixed in
    task automatic flush_header(input logic [SIZE_BITS-1:0] size);
        t_hdr_item it;
        bit        tail_on_eoh;
        int        n;
        n = hdr_buf.size();
        tail_on_eoh = (n > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                it.ch = 8'($urandom); it.has = 1'b0; it.eoh = 1'b0; it.size = rand48();
                append_item(it);
                stim_items++;
            end
            it.ch   = hdr_buf[i];
            it.has  = 1'b1;
            it.eoh  = tail_on_eoh && (i == n - 1);
            it.size = it.eoh ? size : rand48();
            append_item(it);
            stim_items++;
        end
        if (!tail_on_eoh) begin
            it.ch = 8'($urandom); it.has = 1'b0; it.eoh = 1'b1; it.size = size;
            append_item(it);
            stim_items++;
        end
        hdr_buf.delete();
    endtask

    task automatic directed_header(input string s, input logic [SIZE_BITS-1:0] size);
        add_text(s);
        flush_header(size);
    endtask

    function automatic logic [SIZE_BITS-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return POS_LIMIT[SIZE_BITS-1:0];
            2, 3:    return rand48();
            default: return SIZE_BITS'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic string num_text(input logic [SIZE_BITS-1:0] size);
        logic [63:0] v;
        string       s;
        int          n;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 9);
            1:       v = (size == 0) ? 64'd0 : {$urandom, $urandom} % 64'(size);
            2:       v = 64'(size) + $urandom_range(0, 2) - 1;
            3:       v = 64'(rand48());
            4:       v = POS_LIMIT - 2 + $urandom_range(0, 4);
            6:       v = $urandom_range(0, 1000);
            7:       v = 0;
            default: v = 0;
        endcase
        s = $sformatf("%0d", v);
        // long digit run, mostly past the position width
        if ($urandom_range(0, 11) == 0) begin
            n = $urandom_range(15, 22);
            s = "";
            for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        if ($urandom_range(0, 7) == 0) s = {"00", s};
        return s;
    endfunction

    // Break a well-formed header in one of several ways
    task automatic corrupt_header();
        int pos;
        int n;
        case ($urandom_range(0, 5))
            0: hdr_buf[$urandom_range(0, 5)] = 8'($urandom);
            1: begin
                if ($urandom_range(0, 1) == 1) add_text(",0-1");
                else hdr_buf[$urandom_range(0, hdr_buf.size() - 1)] = CHAR_COMMA;
            end
            2: begin
                n = $urandom_range(1, hdr_buf.size());
                while (hdr_buf.size() > n) void'(hdr_buf.pop_back());
            end
            3: begin
                if ($urandom_range(0, 1) == 1) add_text($sformatf("-%0d", $urandom_range(0, 99)));
                else hdr_buf[$urandom_range(6, hdr_buf.size() - 1)] = CHAR_DASH;
            end
            4: begin
                hdr_buf.delete();
                if ($urandom_range(0, 1) == 1) add_text("bytes=");
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) append_char(8'($urandom));
            end
            default: begin
                pos = $urandom_range(6, hdr_buf.size() - 1);
                hdr_buf[pos] = 8'($urandom);
            end
        endcase
    endtask

    task automatic random_header();
        logic [SIZE_BITS-1:0] size;
        size = pick_size();
        if ($urandom_range(0, 19) != 0) begin
            add_text("bytes=");
            case ($urandom_range(0, 2))
                0: add_text({num_text(size), "-", num_text(size)});
                1: add_text({num_text(size), "-"});
                default: add_text({"-", num_text(size)});
            endcase
            if ($urandom_range(0, 3) == 0) corrupt_header();
        end
        flush_header(size);
    endtask

    // Idling is allowed outside the tail and in three of every four windows
    function automatic bit idle_allowed();
        return (pending_items.size() > QUIET_TAIL) && (cycle_count[7:6] != 2'b11);
    endfunction

    // ---------------- driver ----------------
    always @(negedge i_clk) begin : driver
        t_hdr_item it;
        if (i_rst_n) begin
            if (!in_if.valid || in_fired) begin
                if (src_gap > 0) begin
                    in_if.valid <= 1'b0;
                    src_gap--;
                end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
                    in_if.valid <= 1'b0;
                    src_gap = $urandom_range(0, 2);
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    in_if.header_byte   <= it.ch;
                    in_if.has_byte      <= it.has;
                    in_if.end_of_header <= it.eoh;
                    in_if.file_size     <= it.size;
                    in_if.valid         <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ready, with one long hold-off ----------------
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && accepted_items >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_if.ready <= 1'b0;
        end else if (snk_gap > 0) begin
            out_if.ready <= 1'b0;
            snk_gap--;
        end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
            out_if.ready <= 1'b0;
            snk_gap = $urandom_range(0, 2);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ---------------- monitor: check verdicts, predict new ones ----------------
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        in_fired = 1'b0;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict: status %0d first %0d last %0d",
                                 out_if.status, out_if.range_first, out_if.range_last);
                end else begin
                    want = verdict_q.pop_front();
                    if (out_if.status !== want.status || out_if.range_first !== want.first ||
                        out_if.range_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("verdict mismatch: expected %0d %0d..%0d, got %0d %0d..%0d",
                                     want.status, want.first, want.last, out_if.status,
                                     out_if.range_first, out_if.range_last);
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                in_fired = 1'b1;
                accepted_items++;
                if (in_if.has_byte) parse_char(in_if.header_byte);
                if (in_if.end_of_header) begin
                    append_verdict(judge_header(in_if.file_size));
                    clear_parser();
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.header_byte   = '0;
        in_if.has_byte      = 1'b0;
        in_if.end_of_header = 1'b0;
        in_if.file_size     = '0;
        out_if.ready        = 1'b0;
        clear_parser();

        // Directed headers: every verdict path and the width edges
        directed_header("", 48'd1000);
        directed_header("", 48'd0);
        directed_header("bytes=0-499", 48'd1000);
        directed_header("bytes=500-", 48'd1000);
        directed_header("bytes=-200", 48'd1000);
        directed_header("bytes=-2000", 48'd1000);
        directed_header("bytes=-0", 48'd1000);
        directed_header("Bytes=0-1", 48'd1000);
        directed_header("bytes", 48'd1000);
        directed_header("bytes=0-1,2-3", 48'd1000);
        directed_header("bytes=0-1", 48'd0);
        directed_header("bytes=0", 48'd1000);
        directed_header("bytes=0--1", 48'd1000);
        directed_header("bytes=1000-", 48'd1000);
        directed_header("bytes=5-2", 48'd1000);
        directed_header("bytes=0-99999", 48'd1000);
        directed_header("bytes=a-5", 48'd1000);
        directed_header("bytes=5-x", 48'd1000);
        directed_header("bytes=281474976710655-", POS_LIMIT[SIZE_BITS-1:0]);
        directed_header("bytes=281474976710654-281474976710655", POS_LIMIT[SIZE_BITS-1:0]);
        directed_header("bytes=281474976710656-", POS_LIMIT[SIZE_BITS-1:0]);
        directed_header("bytes=-", 48'd1000);
        directed_header("bytes=0-0", 48'd1);
        directed_header("bytes=", 48'd1000);
        directed_header("bytes=-5", POS_LIMIT[SIZE_BITS-1:0]);

        // Random headers fill up the rest of the item budget
        while (stim_items < RANDOM_ITEMS) random_header();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_items.size() != 0 || in_if.valid) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/hbr_pkg.sv
sv/hbr_in_if.sv
sv/hbr_out_if.sv
sv/hbr_front.sv
sv/hbr_queue.sv
sv/hbr_back.sv
sv/http_byte_range_parser.sv
sim/tb_top.sv
